/* rtl/faec_pkg.sv */
package faec_pkg;

    localparam int unsigned TIME_W    = 48;
    localparam int unsigned TAG_W     = 32;
    localparam int unsigned DUR_W     = 32;
    localparam int unsigned KIND_W    = 4;
    localparam int unsigned FLAGS_W   = 5;
    localparam int unsigned S_DATA_W  = 120;
    localparam int unsigned M_DATA_W  = 16;

    localparam logic [DUR_W-1:0] MAX_COUNTDOWN_RESET = DUR_W'(30000);

    localparam int unsigned F_PRESENT   = 0;
    localparam int unsigned F_ALERTED   = 1;
    localparam int unsigned F_ACKED     = 2;
    localparam int unsigned F_SAFE      = 3;
    localparam int unsigned F_CANCELLED = 4;

    typedef enum logic [KIND_W-1:0] {
        EV_TICK         = 4'd0,
        EV_CONNECTED    = 4'd1,
        EV_DISCONNECTED = 4'd2,
        EV_SENSOR_ERROR = 4'd3,
        EV_SENSOR_OK    = 4'd4,
        EV_SUSPECT      = 4'd5,
        EV_COUNTDOWN    = 4'd6,
        EV_SOS          = 4'd7,
        EV_ACK          = 4'd8,
        EV_STOP_BUZZER  = 4'd9,
        EV_CANCEL       = 4'd10,
        EV_SAFE         = 4'd11
    } ev_kind_t;

    typedef enum logic [2:0] {
        ST_APPLIED  = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_INVALID  = 3'd2,
        ST_BUSY     = 3'd3,
        ST_WRONG_ID = 3'd4,
        ST_CLOCK    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        MM_MONITORING = 3'd0,
        MM_DEGRADED   = 3'd1,
        MM_SUSPECTED  = 3'd2,
        MM_VERIFYING  = 3'd3,
        MM_ALERTING   = 3'd4
    } mach_mode_t;

    typedef struct packed {
        logic [DUR_W-1:0]  remaining_ms;
        logic [TAG_W-1:0]  event_tag;
        logic [TIME_W-1:0] now_ms;
        logic [KIND_W-1:0] mode;
    } item_t;

    typedef struct packed {
        logic       buzzer_on;
        mach_mode_t machine_mode;
        logic       sensor_changed;
        logic       record_changed;
        logic       do_stop_buzzer;
        logic       do_start_buzzer;
        logic       do_publish;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic               clock_known;
        logic [TIME_W-1:0]  last_time;
        logic               armed;
        logic [TIME_W-1:0]  deadline;
        logic               sensor_healthy;
        mach_mode_t         mode;
        logic               buzzer;
        logic [FLAGS_W-1:0] act_flags;
        logic [TAG_W-1:0]   act_tag;
        logic [FLAGS_W-1:0] fin_flags;
        logic [TAG_W-1:0]   fin_tag;
    } state_t;

    typedef struct packed {
        logic load;
        logic out_free;
    } flow_t;

endpackage

/* rtl/faec_in_reg.sv */
module faec_in_reg
    import faec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  flow_t               flow,
    output logic                item_valid,
    output item_t               item
);

    logic  vld_reg;
    item_t data_reg;

    assign s_tready   = !vld_reg || flow.load;
    assign item_valid = vld_reg;
    assign item       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= s_tdata[$bits(item_t)-1:0];
        end
    end

endmodule

/* rtl/faec_core.sv */
module faec_core
    import faec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DUR_W-1:0] cfg_data,
    input  flow_t            flow,
    input  item_t            item,
    output result_t          result
);

    localparam state_t STATE_RESET = '{
        clock_known:    1'b0,
        last_time:      '0,
        armed:          1'b0,
        deadline:       '0,
        sensor_healthy: 1'b1,
        mode:           MM_MONITORING,
        buzzer:         1'b0,
        act_flags:      '0,
        act_tag:        '0,
        fin_flags:      '0,
        fin_tag:        '0
    };

    logic [DUR_W-1:0] max_cd_reg;
    state_t           state_reg;
    state_t           state_next;

    logic             present;
    logic             already;
    logic             go;
    logic             ev_match;
    logic             fin_match;
    logic             healthy_in;
    logic [TIME_W:0]  cand;
    status_t          st;
    logic             a_pub;
    logic             a_start;
    logic             a_stop;
    logic             a_rec;
    logic             a_sens;

    assign cfg_ready = 1'b1;
    assign cand      = {1'b0, item.now_ms} + {{(TIME_W + 1 - DUR_W){1'b0}}, item.remaining_ms};

    always_comb
    begin
        state_next = state_reg;
        st         = ST_APPLIED;
        a_pub      = 1'b0;
        a_start    = 1'b0;
        a_stop     = 1'b0;
        a_rec      = 1'b0;
        a_sens     = 1'b0;
        go         = 1'b0;
        already    = 1'b0;
        present    = state_reg.act_flags[F_PRESENT];
        ev_match   = state_reg.act_tag == item.event_tag;
        fin_match  = state_reg.fin_flags[F_PRESENT] && (state_reg.fin_tag == item.event_tag);
        healthy_in = item.mode == EV_SENSOR_OK;

        if (state_reg.clock_known && (item.now_ms < state_reg.last_time))
        begin
            st = ST_CLOCK;
        end
        else
        begin
            state_next.clock_known = 1'b1;
            state_next.last_time   = item.now_ms;

            // raise the alert on an expired deadline before handling the request
            if (state_reg.armed && (item.now_ms >= state_reg.deadline)
                && !state_next.act_flags[F_ALERTED])
            begin
                state_next.act_flags[F_ALERTED] = 1'b1;
                state_next.armed                = 1'b0;
                state_next.mode                 = MM_ALERTING;
                state_next.buzzer               = 1'b1;
                a_pub                           = 1'b1;
                a_start                         = 1'b1;
                a_rec                           = 1'b1;
            end

            unique case (item.mode)
                EV_TICK, EV_CONNECTED, EV_DISCONNECTED:
                begin
                    st = ST_APPLIED;
                end
                EV_SENSOR_ERROR, EV_SENSOR_OK:
                begin
                    if (healthy_in == state_reg.sensor_healthy)
                    begin
                        st = ST_IGNORED;
                    end
                    else
                    begin
                        state_next.sensor_healthy = healthy_in;
                        a_sens                    = 1'b1;
                        if (!present)
                        begin
                            state_next.mode = healthy_in ? MM_MONITORING : MM_DEGRADED;
                        end
                    end
                end
                EV_SUSPECT, EV_COUNTDOWN, EV_SOS:
                begin
                    if (item.event_tag == '0)
                    begin
                        st = ST_INVALID;
                    end
                    else if ((item.mode == EV_COUNTDOWN)
                             && ((item.remaining_ms == '0) || (item.remaining_ms > max_cd_reg)
                                 || cand[TIME_W]))
                    begin
                        st = ST_INVALID;
                    end
                    else if (present)
                    begin
                        if (item.mode == EV_SOS)
                        begin
                            already = state_next.act_flags[F_ALERTED];
                            go      = 1'b1;
                        end
                        else if (!ev_match)
                        begin
                            st = ST_BUSY;
                        end
                        else if ((item.mode == EV_SUSPECT) || state_next.act_flags[F_ALERTED])
                        begin
                            st = ST_IGNORED;
                        end
                        else
                        begin
                            go = 1'b1;
                        end
                    end
                    else if (fin_match)
                    begin
                        st = ST_IGNORED;
                    end
                    else
                    begin
                        state_next.act_flags            = '0;
                        state_next.act_flags[F_PRESENT] = 1'b1;
                        state_next.act_tag              = item.event_tag;
                        a_pub                           = 1'b1;
                        a_rec                           = 1'b1;
                        go                              = 1'b1;
                    end

                    if (go)
                    begin
                        if (item.mode == EV_SOS)
                        begin
                            st = already ? ST_IGNORED : ST_APPLIED;
                            if (!state_next.act_flags[F_ALERTED])
                            begin
                                state_next.act_flags[F_ALERTED] = 1'b1;
                                state_next.armed                = 1'b0;
                                state_next.mode                 = MM_ALERTING;
                                state_next.buzzer               = 1'b1;
                                a_pub                           = 1'b1;
                                a_start                         = 1'b1;
                                a_rec                           = 1'b1;
                            end
                        end
                        else if (item.mode == EV_SUSPECT)
                        begin
                            state_next.mode = MM_SUSPECTED;
                        end
                        else if (state_next.armed)
                        begin
                            if (cand[TIME_W-1:0] >= state_next.deadline)
                            begin
                                st = ST_IGNORED;
                            end
                            else
                            begin
                                state_next.deadline = cand[TIME_W-1:0];
                            end
                        end
                        else
                        begin
                            state_next.deadline = cand[TIME_W-1:0];
                            state_next.armed    = 1'b1;
                            state_next.mode     = MM_VERIFYING;
                            state_next.buzzer   = 1'b1;
                            a_start             = 1'b1;
                        end
                    end
                end
                EV_ACK, EV_STOP_BUZZER, EV_CANCEL, EV_SAFE:
                begin
                    if (item.event_tag == '0)
                    begin
                        st = ST_INVALID;
                    end
                    else if (!present)
                    begin
                        st = fin_match ? ST_IGNORED : ST_WRONG_ID;
                    end
                    else if (!ev_match)
                    begin
                        st = ST_WRONG_ID;
                    end
                    else if (item.mode == EV_ACK)
                    begin
                        if (state_next.act_flags[F_ACKED])
                        begin
                            st = ST_IGNORED;
                        end
                        else
                        begin
                            state_next.act_flags[F_ACKED] = 1'b1;
                            a_rec                         = 1'b1;
                        end
                    end
                    else if (item.mode == EV_STOP_BUZZER)
                    begin
                        if (!state_next.buzzer)
                        begin
                            st = ST_IGNORED;
                        end
                        else
                        begin
                            state_next.buzzer = 1'b0;
                            a_stop            = 1'b1;
                        end
                    end
                    else
                    begin
                        // close the active event and keep it as the finished one
                        state_next.fin_flags                 = '0;
                        state_next.fin_flags[F_PRESENT]      = state_next.act_flags[F_PRESENT];
                        state_next.fin_flags[F_ALERTED]      = state_next.act_flags[F_ALERTED];
                        state_next.fin_flags[F_ACKED]        = state_next.act_flags[F_ACKED];
                        state_next.fin_flags[F_SAFE]         = item.mode == EV_SAFE;
                        state_next.fin_flags[F_CANCELLED]    = item.mode != EV_SAFE;
                        state_next.fin_tag                   = state_next.act_tag;
                        state_next.act_flags                 = '0;
                        state_next.act_tag                   = '0;
                        state_next.armed                     = 1'b0;
                        state_next.deadline                  = '0;
                        a_stop                               = a_stop | state_next.buzzer;
                        state_next.buzzer                    = 1'b0;
                        state_next.mode = state_next.sensor_healthy ? MM_MONITORING : MM_DEGRADED;
                        a_rec                                = 1'b1;
                        a_pub                                = 1'b1;
                    end
                end
                default:
                begin
                    st = ST_INVALID;
                end
            endcase
        end

        result.status          = st;
        result.do_publish      = a_pub;
        result.do_start_buzzer = a_start;
        result.do_stop_buzzer  = a_stop;
        result.record_changed  = a_rec;
        result.sensor_changed  = a_sens;
        result.machine_mode    = state_next.mode;
        result.buzzer_on       = state_next.buzzer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cd_reg <= MAX_COUNTDOWN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_cd_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (flow.load)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/faec_out_reg.sv */
module faec_out_reg
    import faec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  result_t             result,
    output flow_t               flow,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic    vld_reg;
    result_t data_reg;

    assign flow.out_free = !vld_reg || m_tready;
    assign flow.load     = item_valid && flow.out_free;
    assign m_tvalid      = vld_reg;
    assign m_tdata       = {{(M_DATA_W - $bits(result_t)){1'b0}}, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (flow.out_free)
        begin
            vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.load)
        begin
            data_reg <= result;
        end
    end

endmodule

/* rtl/fall_alert_event_controller.sv */
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tdata: event request
// m_*       out        m_tvalid / m_tready   m_tdata: step result
// cfg_*     in         cfg_valid / cfg_ready cfg_data: max_countdown_ms
//
// One request per cycle while the result side does not stall.
// The request register feeds one pass of step logic into the result register and state.
// Reset clears state, sets the sensor healthy and max_countdown_ms to 30000.
// A held result stalls the step; a full request register then holds and s_tready drops.
module fall_alert_event_controller
    import faec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // mode[3:0], now_ms[51:4], event_tag[83:52], remaining_ms[115:84], zero[119:116]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[2:0], do_publish[3], do_start_buzzer[4], do_stop_buzzer[5],
    // record_changed[6], sensor_changed[7], machine_mode[10:8], buzzer_on[11], zero[15:12]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DUR_W-1:0]    cfg_data
);

    flow_t   flow;
    logic    item_valid;
    item_t   item;
    result_t result;

    faec_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .flow       (flow),
        .item_valid (item_valid),
        .item       (item)
    );

    faec_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .flow      (flow),
        .item      (item),
        .result    (result)
    );

    faec_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .flow       (flow),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* rtl/faec_checker.sv */
module faec_checker
    import faec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_CLOCK)
        else $error("status out of range");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10:8] <= MM_ALERTING)
        else $error("machine mode out of range");

    a_start_on: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] && !m_tdata[5] |-> m_tdata[11])
        else $error("buzzer started but reported off");

    a_clock_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == ST_CLOCK) |-> m_tdata[7:3] == '0)
        else $error("actions raised on reversed clock");

endmodule

bind fall_alert_event_controller faec_checker u_faec_checker (.*);
